@@ hw/rtl/assert_macros.svh @@
// Assertion helpers, included by the top-level evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property a must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, a, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a)) else $error(msg);

// When a holds, b must hold on the following clock edge.
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/iee_pkg.sv @@
`default_nettype none

package iee_pkg;

  // Storage and number format.
  localparam int StackDepth   = 32;
  localparam int PtrW         = $clog2(StackDepth);
  localparam int CntW         = $clog2(StackDepth + 1);
  localparam int ValW         = 48;
  localparam int FracBits     = 16;
  localparam int TokW         = 4;
  localparam int OpW          = 3;
  localparam int StatW        = 3;

  // Token kinds.
  localparam logic [TokW-1:0] TOK_NUM   = 4'd0;
  localparam logic [TokW-1:0] TOK_PLUS  = 4'd1;
  localparam logic [TokW-1:0] TOK_MINUS = 4'd2;
  localparam logic [TokW-1:0] TOK_TIMES = 4'd3;
  localparam logic [TokW-1:0] TOK_DIV   = 4'd4;
  localparam logic [TokW-1:0] TOK_MOD   = 4'd5;
  localparam logic [TokW-1:0] TOK_OPEN  = 4'd6;
  localparam logic [TokW-1:0] TOK_CLOSE = 4'd7;
  localparam logic [TokW-1:0] TOK_END   = 4'd8;

  // Operator stack codes.
  localparam logic [OpW-1:0] OP_PLUS  = 3'd1;
  localparam logic [OpW-1:0] OP_MINUS = 3'd2;
  localparam logic [OpW-1:0] OP_TIMES = 3'd3;
  localparam logic [OpW-1:0] OP_DIV   = 3'd4;
  localparam logic [OpW-1:0] OP_MOD   = 3'd5;
  localparam logic [OpW-1:0] OP_OPEN  = 3'd6;

  // Status codes.
  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_DIV_ZERO = 3'd1;
  localparam logic [StatW-1:0] ST_MISSING  = 3'd2;
  localparam logic [StatW-1:0] ST_EMPTY    = 3'd3;
  localparam logic [StatW-1:0] ST_OVERFLOW = 3'd4;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH_NUM,
    CMD_PUSH_OP,
    CMD_POP_OP,
    CMD_READ_TOP,
    CMD_READ_R,
    CMD_READ_L,
    CMD_ARITH,
    CMD_START_DIV,
    CMD_FINISH_DIV,
    CMD_CLEAR
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t          cmd;
    logic [OpW-1:0]  op;
    logic            set_err;
    logic [StatW-1:0] err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] val_cnt;
    logic [CntW-1:0] op_cnt;
    logic [OpW-1:0]  top_op;
    logic            div_done;
    logic            div_zero;
  } dp_stat_t;

  // Binding strength of an operator code.
  function automatic logic [1:0] prec(input logic [OpW-1:0] op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_PLUS || op == OP_MINUS) p = 2'd1;
    else if (op == OP_TIMES || op == OP_DIV || op == OP_MOD) p = 2'd2;
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/iee_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. Divides a 128-bit
// magnitude by a 64-bit magnitude and flags a quotient wider than 49 bits.
module iee_divider (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] dividend,
  input  wire logic [63:0]  divisor,
  output logic              done,
  output logic [49:0]       quot,
  output logic              big,
  output logic [63:0]       rem
);

  logic [127:0] num;
  logic [63:0]  den;
  logic [6:0]   cnt;
  logic         busy;
  logic [64:0]  trial;
  logic [64:0]  shifted;

  // One shift-subtract step.
  always_comb begin
    shifted = {rem, num[127]};
    trial   = shifted - {1'b0, den};
  end

  // Iteration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        quot <= '0;
        big  <= 1'b0;
      end else if (busy) begin
        num <= {num[126:0], 1'b0};
        if (!trial[64]) rem <= trial[63:0];
        else            rem <= shifted[63:0];
        if (!big) begin
          quot <= {quot[48:0], ~trial[64]};
          if (quot[48]) big <= 1'b1;
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/iee_datapath.sv @@
`default_nettype none

// Stacks, operand registers and arithmetic units.
module iee_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire iee_pkg::dp_cmd_t            cmd,
  input  wire logic [iee_pkg::ValW-1:0]    num_in,
  output iee_pkg::dp_stat_t                stat,
  output logic [iee_pkg::ValW-1:0]         top_val,
  output logic [iee_pkg::StatW-1:0]        err
);

  localparam int VW = iee_pkg::ValW;
  localparam int FB = iee_pkg::FracBits;
  localparam int PW = iee_pkg::PtrW;
  localparam int CW = iee_pkg::CntW;

  logic [VW-1:0]           vmem [iee_pkg::StackDepth];
  logic [iee_pkg::OpW-1:0] omem [iee_pkg::StackDepth];
  logic [CW-1:0]           vcnt;
  logic [CW-1:0]           ocnt;
  logic [VW-1:0]           rd_data;
  logic [iee_pkg::OpW-1:0] otop;
  logic signed [VW-1:0]    lv;
  logic signed [VW-1:0]    rv;
  logic [iee_pkg::OpW-1:0] cur_op;

  // Saturating add and subtract.
  logic signed [VW:0] sum_w;
  logic signed [VW:0] dif_w;
  logic [VW-1:0]      sum_s;
  logic [VW-1:0]      dif_s;
  localparam logic signed [VW:0] MaxV = (VW+1)'((64'sd1 <<< (VW-1)) - 1);
  localparam logic signed [VW:0] MinV = -(VW+1)'(64'sd1 <<< (VW-1));

  always_comb begin
    sum_w = {lv[VW-1], lv} + {rv[VW-1], rv};
    dif_w = {lv[VW-1], lv} - {rv[VW-1], rv};
    if (sum_w > MaxV)      sum_s = MaxV[VW-1:0];
    else if (sum_w < MinV) sum_s = MinV[VW-1:0];
    else                   sum_s = sum_w[VW-1:0];
    if (dif_w > MaxV)      dif_s = MaxV[VW-1:0];
    else if (dif_w < MinV) dif_s = MinV[VW-1:0];
    else                   dif_s = dif_w[VW-1:0];
  end

  // Magnitudes and sign of the operands.
  logic [VW-1:0] lmag;
  logic [VW-1:0] rmag;
  logic          neg;
  assign lmag = lv[VW-1] ? VW'(-lv) : VW'(lv);
  assign rmag = rv[VW-1] ? VW'(-rv) : VW'(rv);
  assign neg  = lv[VW-1] ^ rv[VW-1];

  // Integer parts for modulo, truncated toward zero.
  logic [VW-1:0] lint;
  logic [VW-1:0] rint;
  assign lint = lmag >> FB;
  assign rint = rmag >> FB;

  // Product magnitude: four registered 24x24 partial products, summed next.
  logic [47:0] pp0;
  logic [47:0] pp1;
  logic [47:0] pp2;
  logic [47:0] pp3;
  logic [95:0] prod;
  assign prod = {48'd0, pp0} + ({48'd0, pp1} << 24) + ({48'd0, pp2} << 24)
              + ({48'd0, pp3} << 48);

  function automatic logic [VW-1:0] sat_mag(input logic n, input logic [127:0] m);
    logic [VW-1:0] r;
    if (n) begin
      if (m > 128'(64'h8000_0000_0000)) r = 48'h8000_0000_0000;
      else r = VW'(-m[VW-1:0]);
    end else begin
      if (m > 128'(64'h7FFF_FFFF_FFFF)) r = 48'h7FFF_FFFF_FFFF;
      else r = m[VW-1:0];
    end
    return r;
  endfunction

  // Divider shared by division and modulo.
  logic         dstart;
  logic [127:0] ddend;
  logic [63:0]  dsor;
  logic         ddone;
  logic [49:0]  dquot;
  logic         dbig;
  logic [63:0]  drem;
  logic         is_mod;

  assign dstart = (cmd.cmd == iee_pkg::CMD_START_DIV);
  always_comb begin
    if (cmd.op == iee_pkg::OP_MOD) begin
      ddend = {80'd0, lint};
      dsor  = {16'd0, rint};
    end else begin
      ddend = {80'd0, lmag} << FB;
      dsor  = {16'd0, rmag};
    end
  end

  iee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dstart),
    .dividend (ddend),
    .divisor  (dsor),
    .done     (ddone),
    .quot     (dquot),
    .big      (dbig),
    .rem      (drem)
  );

  // Result to push back.
  logic [VW-1:0] res;
  logic [VW-1:0] modv;
  assign modv = (lv[VW-1] ? VW'(-drem[VW-1:0]) : drem[VW-1:0]) << FB;
  always_comb begin
    res = '0;
    case (cur_op)
      iee_pkg::OP_PLUS:  res = sum_s;
      iee_pkg::OP_MINUS: res = dif_s;
      iee_pkg::OP_TIMES: res = sat_mag(neg, {32'd0, prod} >> FB);
      iee_pkg::OP_DIV:   res = sat_mag(neg, {77'd0, dbig, dquot});
      default:           res = modv;
    endcase
  end

  assign is_mod = (cur_op == iee_pkg::OP_MOD);

  // Stack pushes and pops.
  logic          push_v;
  logic [VW-1:0] push_d;
  always_comb begin
    push_v = 1'b0;
    push_d = num_in;
    if (cmd.cmd == iee_pkg::CMD_PUSH_NUM) push_v = 1'b1;
    else if (cmd.cmd == iee_pkg::CMD_ARITH || cmd.cmd == iee_pkg::CMD_FINISH_DIV) begin
      push_v = 1'b1;
      push_d = res;
    end
  end

  always_ff @(posedge clk) begin
    if (push_v && vcnt < CW'(iee_pkg::StackDepth)) vmem[vcnt[PW-1:0]] <= push_d;
    if (cmd.cmd == iee_pkg::CMD_PUSH_OP && ocnt < CW'(iee_pkg::StackDepth))
      omem[ocnt[PW-1:0]] <= cmd.op;
    rd_data <= vmem[PW'(vcnt - CW'(1))];
    otop    <= omem[PW'(ocnt - CW'(1))];
  end

  always_ff @(posedge clk) begin
    pp0 <= lmag[23:0]  * rmag[23:0];
    pp1 <= lmag[47:24] * rmag[23:0];
    pp2 <= lmag[23:0]  * rmag[47:24];
    pp3 <= lmag[47:24] * rmag[47:24];
    if (cmd.cmd == iee_pkg::CMD_READ_R) rv <= rd_data;
    if (cmd.cmd == iee_pkg::CMD_READ_L) begin
      lv     <= rd_data;
      cur_op <= cmd.op;
    end
  end

  // Counters and sticky error.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
      ocnt <= '0;
      err  <= iee_pkg::ST_OK;
    end else begin
      if (cmd.set_err && err == iee_pkg::ST_OK) err <= cmd.err_code;
      unique case (cmd.cmd)
        iee_pkg::CMD_PUSH_NUM, iee_pkg::CMD_ARITH, iee_pkg::CMD_FINISH_DIV: begin
          if (vcnt < CW'(iee_pkg::StackDepth)) vcnt <= vcnt + CW'(1);
          else if (err == iee_pkg::ST_OK) err <= iee_pkg::ST_OVERFLOW;
        end
        iee_pkg::CMD_PUSH_OP: begin
          if (ocnt < CW'(iee_pkg::StackDepth)) ocnt <= ocnt + CW'(1);
          else if (err == iee_pkg::ST_OK) err <= iee_pkg::ST_OVERFLOW;
        end
        iee_pkg::CMD_POP_OP: ocnt <= ocnt - CW'(1);
        iee_pkg::CMD_READ_R, iee_pkg::CMD_READ_L: vcnt <= vcnt - CW'(1);
        iee_pkg::CMD_CLEAR: begin
          vcnt <= '0;
          ocnt <= '0;
          err  <= iee_pkg::ST_OK;
        end
        default: ;
      endcase
    end
  end

  assign stat.val_cnt  = vcnt;
  assign stat.op_cnt   = ocnt;
  assign stat.top_op   = otop;
  assign stat.div_done = ddone;
  assign stat.div_zero = is_mod ? (rint == '0) : (rv == '0);
  assign top_val       = rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/iee_control.sv @@
`default_nettype none

// Token sequencer: unwinds the operator stack and steps the datapath.
module iee_control (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [iee_pkg::TokW-1:0]   req_type,
  input  wire iee_pkg::dp_stat_t          stat,
  input  wire logic [iee_pkg::ValW-1:0]   top_val,
  input  wire logic [iee_pkg::StatW-1:0]  err,
  output iee_pkg::dp_cmd_t                cmd,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [iee_pkg::ValW-1:0]        result_value,
  output logic [iee_pkg::StatW-1:0]       status
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETTLE, S_CHECK, S_POPR, S_POPL, S_WAITL, S_EXEC,
    S_MUL, S_DIVW, S_PUSHOP, S_RESULT, S_OUT
  } state_t;

  state_t                  state;
  logic [iee_pkg::TokW-1:0] tok;
  logic [iee_pkg::OpW-1:0]  op;
  logic                     halted;
  iee_pkg::dp_cmd_t         idle_cmd;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Command that leaves the datapath alone.
  assign idle_cmd = '{iee_pkg::CMD_NONE, op, 1'b0, iee_pkg::ST_OK};

  // Whether the top operator should be applied now, or an open dropped at the end token.
  logic unwind;
  logic drop_open;
  always_comb begin
    unwind    = 1'b0;
    drop_open = 1'b0;
    if (stat.op_cnt != '0) begin
      if (tok == iee_pkg::TOK_END) begin
        unwind    = stat.top_op != iee_pkg::OP_OPEN;
        drop_open = stat.top_op == iee_pkg::OP_OPEN;
      end else if (stat.top_op != iee_pkg::OP_OPEN) begin
        unwind = (tok == iee_pkg::TOK_CLOSE) ||
                 (iee_pkg::prec(stat.top_op) >= iee_pkg::prec(tok[iee_pkg::OpW-1:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      halted    <= 1'b0;
      cmd       <= '{iee_pkg::CMD_NONE, '0, 1'b0, iee_pkg::ST_OK};
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            tok <= req_type;
            if (req_type == iee_pkg::TOK_NUM) begin
              cmd <= '{iee_pkg::CMD_PUSH_NUM, op, 1'b0, iee_pkg::ST_OK};
            end else if (req_type == iee_pkg::TOK_OPEN) begin
              cmd <= '{iee_pkg::CMD_PUSH_OP, iee_pkg::OP_OPEN, 1'b0, iee_pkg::ST_OK};
            end else begin
              cmd <= idle_cmd;
              if (req_type >= iee_pkg::TOK_PLUS && req_type <= iee_pkg::TOK_END) begin
                state <= S_SETTLE;
              end
            end
          end else begin
            cmd <= idle_cmd;
          end
        end
        // S_SETTLE waits while the counts and then the registered stack tops follow a pop.
        S_SETTLE: begin
          cmd    <= idle_cmd;
          halted <= !halted;
          if (halted) state <= S_CHECK;
        end
        S_CHECK: begin
          if (unwind) begin
            op <= stat.top_op;
            if (stat.val_cnt < iee_pkg::CntW'(2)) begin
              cmd <= '{iee_pkg::CMD_POP_OP, stat.top_op, 1'b1, iee_pkg::ST_MISSING};
              state <= S_SETTLE;
            end else begin
              cmd <= '{iee_pkg::CMD_READ_R, stat.top_op, 1'b0, iee_pkg::ST_OK};
              state <= S_POPR;
            end
          end else if (drop_open) begin
            cmd   <= '{iee_pkg::CMD_POP_OP, op, 1'b0, iee_pkg::ST_OK};
            state <= S_SETTLE;
          end else if (tok == iee_pkg::TOK_CLOSE) begin
            if (stat.op_cnt != '0) begin
              cmd <= '{iee_pkg::CMD_POP_OP, op, 1'b0, iee_pkg::ST_OK};
            end else begin
              cmd <= idle_cmd;
            end
            state <= S_IDLE;
          end else if (tok == iee_pkg::TOK_END) begin
            cmd   <= idle_cmd;
            state <= S_RESULT;
          end else begin
            cmd <= '{iee_pkg::CMD_PUSH_OP, tok[iee_pkg::OpW-1:0], 1'b0, iee_pkg::ST_OK};
            state <= S_IDLE;
          end
        end
        // S_POPR waits while the registered read data for the left operand follows the pop.
        S_POPR: begin
          cmd   <= idle_cmd;
          state <= S_POPL;
        end
        S_POPL: begin
          cmd <= '{iee_pkg::CMD_READ_L, op, 1'b0, iee_pkg::ST_OK};
          state <= S_WAITL;
        end
        S_WAITL: begin
          cmd   <= idle_cmd;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (op == iee_pkg::OP_DIV || op == iee_pkg::OP_MOD) begin
            if (stat.div_zero) begin
              cmd <= '{iee_pkg::CMD_POP_OP, op, 1'b1, iee_pkg::ST_DIV_ZERO};
              state <= S_SETTLE;
            end else begin
              cmd   <= '{iee_pkg::CMD_START_DIV, op, 1'b0, iee_pkg::ST_OK};
              state <= S_DIVW;
            end
          end else begin
            cmd   <= idle_cmd;
            state <= S_MUL;
          end
        end
        // Partial products are registered; push the result and pop the operator.
        S_MUL: begin
          halted <= !halted;
          if (halted) begin
            cmd   <= '{iee_pkg::CMD_ARITH, op, 1'b0, iee_pkg::ST_OK};
            state <= S_PUSHOP;
          end else begin
            cmd <= idle_cmd;
          end
        end
        S_DIVW: begin
          if (stat.div_done) begin
            cmd   <= '{iee_pkg::CMD_FINISH_DIV, op, 1'b0, iee_pkg::ST_OK};
            state <= S_PUSHOP;
          end else begin
            cmd <= idle_cmd;
          end
        end
        S_PUSHOP: begin
          cmd   <= '{iee_pkg::CMD_POP_OP, op, 1'b0, iee_pkg::ST_OK};
          state <= S_SETTLE;
        end
        S_RESULT: begin
          out_valid <= 1'b1;
          if (err != iee_pkg::ST_OK) begin
            status       <= err;
            result_value <= '0;
          end else if (stat.val_cnt == '0) begin
            status       <= iee_pkg::ST_EMPTY;
            result_value <= '0;
          end else begin
            status       <= iee_pkg::ST_OK;
            result_value <= top_val;
          end
          cmd   <= '{iee_pkg::CMD_CLEAR, op, 1'b0, iee_pkg::ST_OK};
          state <= S_OUT;
        end
        S_OUT: begin
          cmd   <= idle_cmd;
          state <= S_IDLE;
        end
        default: begin
          cmd   <= idle_cmd;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/infix_expression_evaluator.sv @@
`default_nettype none

// Infix expression evaluator over signed Q32.16 numbers with an operator
// stack and a value stack of 32 entries each. Numbers and open parentheses
// are pushed straight from the idle state. An operator, close or end token
// first inspects the stack, then applies the stacked + - * and each / or %,
// the latter through the 128-step bit-serial divider; an operator with a
// missing operand or a zero divisor sets the error and is popped unapplied.
// The end token then presents one result transaction and clears both
// stacks; a new token is taken once that result has been taken.
module infix_expression_evaluator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [iee_pkg::TokW-1:0]      req_type,
  input  wire logic signed [iee_pkg::ValW-1:0] operand_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [iee_pkg::ValW-1:0]    result_value,
  output logic [iee_pkg::StatW-1:0]          status
);

  iee_pkg::dp_cmd_t               cmd;
  iee_pkg::dp_stat_t              stat;
  logic [iee_pkg::ValW-1:0]       top_val;
  logic [iee_pkg::StatW-1:0]      err;
  logic [iee_pkg::ValW-1:0]       num_reg;
  logic [iee_pkg::ValW-1:0]       res_u;

  // Hold the number of the accepted transaction for the push.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) num_reg <= operand_value;
  end

  iee_control u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .stat         (stat),
    .top_val      (top_val),
    .err          (err),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (res_u),
    .status       (status)
  );

  iee_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .num_in  (num_reg),
    .stat    (stat),
    .top_val (top_val),
    .err     (err)
  );

  assign result_value = res_u;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_vcnt_range, clk, rst, stat.val_cnt <= iee_pkg::CntW'(iee_pkg::StackDepth), "value count past depth")
  `ASSERT_ALWAYS(a_ocnt_range, clk, rst, stat.op_cnt <= iee_pkg::CntW'(iee_pkg::StackDepth), "operator count past depth")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_value), "result dropped while stalled")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam longint SatMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SatMin = -64'sh0000_8000_0000_0000;
  localparam int TotalTokens = 1350;
  localparam int QuietFrom = 1200;
  localparam int CycleLimit = 3000000;

  // Shunting-yard predictor plus the queue of results still owed by the block.
  class result_board;
    longint vals[iee_pkg::StackDepth];
    logic [iee_pkg::OpW-1:0] ops[iee_pkg::StackDepth];
    int nvals;
    int nops;
    logic [iee_pkg::StatW-1:0] first_err;
    longint owed_value[$];
    logic [iee_pkg::StatW-1:0] owed_status[$];
    int fails;

    function new();
      nvals = 0;
      nops = 0;
      first_err = iee_pkg::ST_OK;
      fails = 0;
    endfunction

    function void raise(logic [iee_pkg::StatW-1:0] code);
      if (first_err == iee_pkg::ST_OK) first_err = code;
    endfunction

    function void push_val(longint v);
      if (nvals >= iee_pkg::StackDepth) begin
        raise(iee_pkg::ST_OVERFLOW);
        return;
      end
      vals[nvals] = v;
      nvals++;
    endfunction

    function void push_op(logic [iee_pkg::OpW-1:0] op);
      if (nops >= iee_pkg::StackDepth) begin
        raise(iee_pkg::ST_OVERFLOW);
        return;
      end
      ops[nops] = op;
      nops++;
    endfunction

    function logic [127:0] magnitude(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m;
    endfunction

    // Signed result from sign and magnitude, saturated to the 48-bit range.
    function longint from_mag(bit neg, logic [127:0] m);
      if (neg) begin
        if (m > 128'h8000_0000_0000) return SatMin;
        return -longint'(m[63:0]);
      end
      if (m > 128'h7FFF_FFFF_FFFF) return SatMax;
      return longint'(m[63:0]);
    endfunction

    function int strength(logic [iee_pkg::OpW-1:0] op);
      if (op == iee_pkg::OP_PLUS || op == iee_pkg::OP_MINUS) return 1;
      if (op == iee_pkg::OP_TIMES || op == iee_pkg::OP_DIV || op == iee_pkg::OP_MOD) return 2;
      return 0;
    endfunction

    function void reduce(logic [iee_pkg::OpW-1:0] op);
      longint lhs, rhs, il, ir, s;
      logic [127:0] q;
      s = longint'(1) << iee_pkg::FracBits;
      if (nvals < 2) begin
        raise(iee_pkg::ST_MISSING);
        return;
      end
      rhs = vals[nvals-1];
      lhs = vals[nvals-2];
      nvals -= 2;
      case (op)
        iee_pkg::OP_PLUS: begin
          s = lhs + rhs;
          push_val(s > SatMax ? SatMax : (s < SatMin ? SatMin : s));
        end
        iee_pkg::OP_MINUS: begin
          s = lhs - rhs;
          push_val(s > SatMax ? SatMax : (s < SatMin ? SatMin : s));
        end
        iee_pkg::OP_TIMES: begin
          q = (magnitude(lhs) * magnitude(rhs)) >> iee_pkg::FracBits;
          push_val(from_mag((lhs < 0) != (rhs < 0), q));
        end
        iee_pkg::OP_DIV: begin
          if (rhs == 0) begin
            raise(iee_pkg::ST_DIV_ZERO);
            return;
          end
          q = (magnitude(lhs) << iee_pkg::FracBits) / magnitude(rhs);
          push_val(from_mag((lhs < 0) != (rhs < 0), q));
        end
        iee_pkg::OP_MOD: begin
          il = lhs / s;
          ir = rhs / s;
          if (ir == 0) begin
            raise(iee_pkg::ST_DIV_ZERO);
            return;
          end
          push_val((il % ir) * s);
        end
        default: ;
      endcase
    endfunction

    // Note one accepted input transaction.
    function void note_token(logic [iee_pkg::TokW-1:0] tok,
                             logic signed [iee_pkg::ValW-1:0] v);
      longint res;
      logic [iee_pkg::StatW-1:0] st;
      case (tok)
        iee_pkg::TOK_NUM: push_val(longint'(v));
        iee_pkg::TOK_PLUS, iee_pkg::TOK_MINUS, iee_pkg::TOK_TIMES, iee_pkg::TOK_DIV,
        iee_pkg::TOK_MOD: begin
          while (nops > 0 && ops[nops-1] != iee_pkg::OP_OPEN &&
                 strength(ops[nops-1]) >= strength(iee_pkg::OpW'(tok))) begin
            reduce(ops[nops-1]);
            nops--;
          end
          push_op(iee_pkg::OpW'(tok));
        end
        iee_pkg::TOK_OPEN: push_op(iee_pkg::OP_OPEN);
        iee_pkg::TOK_CLOSE: begin
          while (nops > 0 && ops[nops-1] != iee_pkg::OP_OPEN) begin
            reduce(ops[nops-1]);
            nops--;
          end
          if (nops > 0) nops--;
        end
        iee_pkg::TOK_END: begin
          while (nops > 0) begin
            if (ops[nops-1] != iee_pkg::OP_OPEN) reduce(ops[nops-1]);
            nops--;
          end
          res = 0;
          st = first_err;
          if (st == iee_pkg::ST_OK) begin
            if (nvals == 0) st = iee_pkg::ST_EMPTY;
            else res = vals[nvals-1];
          end
          owed_value.push_back(res);
          owed_status.push_back(st);
          nvals = 0;
          nops = 0;
          first_err = iee_pkg::ST_OK;
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result transaction with the oldest owed result.
    function void check_result(logic signed [iee_pkg::ValW-1:0] v,
                               logic [iee_pkg::StatW-1:0] st);
      logic signed [iee_pkg::ValW-1:0] ev;
      logic [iee_pkg::StatW-1:0] es;
      if (owed_value.size() == 0) begin
        $error("unexpected result transaction: result_value %0d status %0d", v, st);
        fails++;
        return;
      end
      ev = iee_pkg::ValW'(owed_value.pop_front());
      es = owed_status.pop_front();
      if (v !== ev) begin
        $error("result_value mismatch: expected %0d, actual %0d", ev, v);
        fails++;
      end
      if (st !== es) begin
        $error("status mismatch: expected %0d, actual %0d", es, st);
        fails++;
      end
    endfunction

    function int owed();
      return owed_value.size();
    endfunction
  endclass

  typedef struct {
    logic [iee_pkg::TokW-1:0] tok;
    logic signed [iee_pkg::ValW-1:0] val;
  } token_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [iee_pkg::TokW-1:0] req_type;
  logic signed [iee_pkg::ValW-1:0] operand_value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [iee_pkg::ValW-1:0] result_value;
  logic [iee_pkg::StatW-1:0] status;

  result_board board = new();
  token_t pending_tokens[$];
  int sent;
  bit quiet;
  int cycles = 0;
  int stall_left = 0;

  infix_expression_evaluator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .operand_value(operand_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_value(result_value),
    .status(status)
  );

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("infix_expression_evaluator verification failed");
      $finish;
    end
  end

  // Result side: random stall bursts, none in the quiet tail.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(result_value, status);
  end

  function automatic logic signed [iee_pkg::ValW-1:0] rand_number();
    logic signed [iee_pkg::ValW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = iee_pkg::ValW'({$urandom(), $urandom()});
      1: v = iee_pkg::ValW'(longint'($urandom_range(0, 40)) - 20) <<< iee_pkg::FracBits;
      2: v = iee_pkg::ValW'(longint'($urandom_range(0, 600000)) - 300000);
      3: v = $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
      4: v = '0;
      default: v = iee_pkg::ValW'(longint'($urandom_range(0, 2000)) - 1000)
                   <<< ($urandom_range(8, 20));
    endcase
    return v;
  endfunction

  function automatic void add_token(logic [iee_pkg::TokW-1:0] tok,
                                    logic signed [iee_pkg::ValW-1:0] v);
    token_t t;
    t.tok = tok;
    t.val = v;
    pending_tokens.push_back(t);
  endfunction

  // Well-formed expression: terms joined by random operators, nested parentheses.
  function automatic void gen_expr(int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) begin
        add_token(iee_pkg::TokW'($urandom_range(iee_pkg::TOK_PLUS, iee_pkg::TOK_MOD)),
                  iee_pkg::ValW'({$urandom(), $urandom()}));
      end
      if (depth < 4 && $urandom_range(0, 3) == 0) begin
        add_token(iee_pkg::TOK_OPEN, iee_pkg::ValW'({$urandom(), $urandom()}));
        gen_expr(depth + 1);
        add_token(iee_pkg::TOK_CLOSE, iee_pkg::ValW'({$urandom(), $urandom()}));
      end else begin
        add_token(iee_pkg::TOK_NUM, rand_number());
      end
    end
  endfunction

  // Send one input transaction, now and then after a random idle burst outside the quiet tail.
  task automatic send_token(token_t t);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= t.tok;
    operand_value <= t.val;
    do @(posedge clk); while (!in_ready);
    board.note_token(t.tok, t.val);
    sent++;
  endtask

  task automatic flush_tokens();
    while (pending_tokens.size() > 0) send_token(pending_tokens.pop_front());
  endtask

  initial begin
    int pick;
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = iee_pkg::TOK_NUM;
    operand_value = '0;
    sent = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: precedence, parentheses, division by zero, missing operand, empty result, ignored kinds, extremes.
    add_token(iee_pkg::TOK_NUM, 48'sh1_0000);
    add_token(iee_pkg::TOK_PLUS, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh2_0000);
    add_token(iee_pkg::TOK_TIMES, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh3_0000);
    add_token(iee_pkg::TOK_END, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh7FFF_FFFF_FFFF);
    add_token(iee_pkg::TOK_TIMES, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh7FFF_FFFF_FFFF);
    add_token(iee_pkg::TOK_END, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh8000_0000_0000);
    add_token(iee_pkg::TOK_DIV, '0);
    add_token(iee_pkg::TOK_NUM, '0);
    add_token(iee_pkg::TOK_MOD, '0);
    add_token(iee_pkg::TOK_END, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh7_0000);
    add_token(iee_pkg::TOK_MOD, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh8000);
    add_token(iee_pkg::TOK_END, '0);
    add_token(iee_pkg::TOK_PLUS, '0);
    add_token(iee_pkg::TOK_END, '0);
    add_token(iee_pkg::TOK_CLOSE, '0);
    add_token(iee_pkg::TOK_END, '0);
    add_token(4'd9, '0);
    add_token(4'd15, 48'shFFFF_FFFF_FFFF);
    add_token(iee_pkg::TOK_OPEN, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh8000_0000_0000);
    add_token(iee_pkg::TOK_MINUS, '0);
    add_token(iee_pkg::TOK_NUM, 48'sh1);
    add_token(iee_pkg::TOK_END, '0);
    flush_tokens();

    // Random: mostly well-formed expressions, some noise and runs near or past the stack depth.
    while (sent < TotalTokens) begin
      if (sent >= QuietFrom) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        gen_expr(0);
      end else if (pick < 95) begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          add_token(iee_pkg::TokW'($urandom_range(0, 15)), rand_number());
        end
      end else begin
        n = $urandom_range(iee_pkg::StackDepth - 1, iee_pkg::StackDepth + 4);
        for (int i = 0; i < n; i++) begin
          if (pick < 98) add_token(iee_pkg::TOK_NUM, rand_number());
          else add_token(iee_pkg::TOK_OPEN, '0);
        end
      end
      add_token(iee_pkg::TOK_END, '0);
      flush_tokens();
    end
    in_valid <= 1'b0;

    while (board.owed() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.fails == 0) begin
      $display("infix_expression_evaluator verification clean");
    end else begin
      $display("infix_expression_evaluator verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/iee_pkg.sv
hw/rtl/iee_divider.sv
hw/rtl/iee_datapath.sv
hw/rtl/iee_control.sv
hw/rtl/infix_expression_evaluator.sv
verif/testbench.sv
